// ----- design/pfa_pkg.sv -----
// ---------------------------------------------------------------------------
// pfa_pkg
// Shared types, constants and helpers for the photopic flux accumulator.
// ---------------------------------------------------------------------------
package pfa_pkg;

   // default weight table depth
   localparam int TABLE_DEPTH_DEF = 8192;

   // command codes
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_SAMPLE = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;

   // configuration register indexes
   localparam logic CSR_TABLE_START  = 1'b0;
   localparam logic CSR_TABLE_LENGTH = 1'b1;

   // configuration reset values
   localparam logic [13:0] TABLE_START_RST  = 14'd3600;
   localparam logic [13:0] TABLE_LENGTH_RST = 14'd4701;

   // band edges in tenths of nm
   localparam logic [13:0] BLUE_LO  = 14'd3800;
   localparam logic [13:0] GREEN_LO = 14'd5000;
   localparam logic [13:0] RED_LO   = 14'd6000;
   localparam logic [13:0] RED_HI   = 14'd7800;

   // fixed point constants
   localparam logic [31:0] WEIGHT_ONE = 32'd65536;
   localparam logic [63:0] FLUX_GAIN  = 64'd683;
   localparam logic [63:0] FLUX_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF / 64'd683;
   localparam logic [25:0] EFF_MAX    = 26'd44761088;
   localparam logic [14:0] PCT_SCALE  = 15'd25600;

   // shared divider geometry
   localparam int DIV_N_W   = 80;
   localparam int DIV_D_W   = 64;
   localparam int DIV_CNT_W = $clog2(DIV_N_W);

   // division being run by the shared unit
   typedef enum logic [1:0] {
      DIV_EFF   = 2'd0,
      DIV_RED   = 2'd1,
      DIV_GREEN = 2'd2,
      DIV_BLUE  = 2'd3
   } div_sel_type;

   // input item
   typedef struct packed {
      logic [1:0]  cmd;
      logic [13:0] wavelength_tenths;
      logic [31:0] sample_value;
   } req_item_type;

   // result item
   typedef struct packed {
      logic [63:0] luminous_flux;
      logic [25:0] efficacy;
      logic [14:0] red_percent;
      logic [14:0] green_percent;
      logic [14:0] blue_percent;
      logic        dark_flag;
      logic        no_color_flag;
   } rsp_item_type;

   // saturating 64-bit add
   function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
   endfunction

   // band sum times 25600 (16384 + 8192 + 1024) as divider dividend
   function automatic logic [DIV_N_W-1:0] pct_dividend(input logic [63:0] s);
      logic [DIV_N_W-1:0] x;
      x = {{(DIV_N_W-64){1'b0}}, s};
      return (x << 14) + (x << 13) + (x << 10);
   endfunction

endpackage

// ----- design/pfa_weight_ram.sv -----
// ---------------------------------------------------------------------------
// pfa_weight_ram
// Photopic weight table: one write port, one registered read port.
// ---------------------------------------------------------------------------
module pfa_weight_ram #(
   parameter int DEPTH = pfa_pkg::TABLE_DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [16:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [16:0]   rd_data
);

   logic [16:0] mem_ff [DEPTH];
   logic [16:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/pfa_divider.sv -----
// ---------------------------------------------------------------------------
// pfa_divider
// Shared restoring divider, one quotient bit per cycle, done pulse at end.
// ---------------------------------------------------------------------------
module pfa_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pfa_pkg::DIV_N_W-1:0]  dividend,
   input  logic [pfa_pkg::DIV_D_W-1:0]  divisor,
   output logic                         done,
   output logic [pfa_pkg::DIV_N_W-1:0]  quotient
);

   localparam int NW = pfa_pkg::DIV_N_W;
   localparam int DW = pfa_pkg::DIV_D_W;
   localparam int CW = pfa_pkg::DIV_CNT_W;
   localparam logic [CW-1:0] LAST_STEP = CW'(NW - 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] div_ff, div_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;

   logic [DW:0]   rem_shift;
   logic [DW+1:0] diff;
   logic          ge;

   // one shift-subtract step
   assign rem_shift = {rem_ff, quo_ff[NW-1]};
   assign diff      = {1'b0, rem_shift} - {2'b00, div_ff};
   assign ge        = ~diff[DW+1];

   // sequencing of the steps
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         div_in  = divisor;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DW-1:0] : rem_shift[DW-1:0];
         quo_in = {quo_ff[NW-2:0], ge};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- design/photopic_flux_accumulator_top.sv -----
// Load item: written to the table on accept. Sample item: table read, multiply, accumulate.
// Finish item: the shared 80-step divider is run four times (efficacy and three band
// shares); only once, for efficacy, when there is no band energy, and not when dark.
// A result that is not taken holds the next finish in emit. One item at a time.
// Reset (synchronous, active high) clears the sums and restores the table window;
// weight table contents are undefined until loaded, with no clearing pass.
// ---------------------------------------------------------------------------
// photopic_flux_accumulator_top
// Accumulates weighted spectral energy against a loaded photopic table and
// emits flux, efficacy and band percentages on a finish item.
// ---------------------------------------------------------------------------
module photopic_flux_accumulator_top #(
   parameter int TABLE_DEPTH = pfa_pkg::TABLE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pfa_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pfa_pkg::rsp_item_type rsp_item,
   input  logic                  csr_write_en,
   input  logic                  csr_index,
   input  logic [13:0]           csr_wdata
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam logic [14:0] DEPTH_15 = 15'(TABLE_DEPTH);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_MUL      = 7'b0000010,
      ST_ACC      = 7'b0000100,
      ST_FLUX     = 7'b0001000,
      ST_DIV_GO   = 7'b0010000,
      ST_DIV_WAIT = 7'b0100000,
      ST_EMIT     = 7'b1000000
   } pfa_state_type;

   pfa_state_type state_ff, state_in;
   pfa_pkg::div_sel_type sel_ff, sel_in;

   logic [13:0] start_ff, start_in;
   logic [13:0] length_ff, length_in;

   logic [63:0] energy_ff, energy_in;
   logic [63:0] weighted_ff, weighted_in;
   logic [63:0] red_ff, red_in;
   logic [63:0] green_ff, green_in;
   logic [63:0] blue_ff, blue_in;

   logic [13:0] wl_ff, wl_in;
   logic [31:0] val_ff, val_in;
   logic [48:0] prod_ff, prod_in;
   logic [63:0] flux_ff, flux_in;
   logic [63:0] rgb_ff, rgb_in;
   logic [25:0] eff_ff, eff_in;
   logic [14:0] rp_ff, rp_in;
   logic [14:0] gp_ff, gp_in;
   logic [14:0] bp_ff, bp_in;
   logic        dark_ff, dark_in;
   logic        nocolor_ff, nocolor_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   pfa_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic                        accept;
   logic [14:0]                 off_full;
   logic [13:0]                 off;
   logic                        in_table;
   logic                        load_ok;
   logic                        ram_we;
   logic [16:0]                 ram_wdata;
   logic [16:0]                 ram_rdata;
   logic [63:0]                 t64;
   logic                        div_start;
   logic [pfa_pkg::DIV_N_W-1:0] div_dividend;
   logic [pfa_pkg::DIV_N_W-1:0] div_quotient;
   logic                        div_done;
   logic [14:0]                 pct_q;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;

   // table window check for a sample
   assign off_full = {1'b0, req_item.wavelength_tenths} - {1'b0, start_ff};
   assign off      = off_full[13:0];
   assign in_table = ~off_full[14] && (off < length_ff) && ({1'b0, off} < DEPTH_15);
   assign load_ok  = ({1'b0, req_item.wavelength_tenths} < DEPTH_15);

   // weight load with saturation at 1.0
   assign ram_we    = accept && (req_item.cmd == pfa_pkg::CMD_LOAD) && load_ok;
   assign ram_wdata = (req_item.sample_value > pfa_pkg::WEIGHT_ONE) ?
                      pfa_pkg::WEIGHT_ONE[16:0] : req_item.sample_value[16:0];

   pfa_weight_ram #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_item.wavelength_tenths[AW-1:0]),
      .wr_data (ram_wdata),
      .rd_addr (off[AW-1:0]),
      .rd_data (ram_rdata)
   );

   // divider operand select
   always_comb begin
      case (sel_ff)
         pfa_pkg::DIV_EFF:   div_dividend = {{(pfa_pkg::DIV_N_W-64){1'b0}}, flux_ff};
         pfa_pkg::DIV_RED:   div_dividend = pfa_pkg::pct_dividend(red_ff);
         pfa_pkg::DIV_GREEN: div_dividend = pfa_pkg::pct_dividend(green_ff);
         pfa_pkg::DIV_BLUE:  div_dividend = pfa_pkg::pct_dividend(blue_ff);
         default:            div_dividend = '0;
      endcase
   end

   assign div_start = (state_ff == ST_DIV_GO);

   pfa_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  ((sel_ff == pfa_pkg::DIV_EFF) ? energy_ff : rgb_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // clamped percentage from the divider
   assign pct_q = (div_quotient > {{(pfa_pkg::DIV_N_W-15){1'b0}}, pfa_pkg::PCT_SCALE}) ?
                  pfa_pkg::PCT_SCALE : div_quotient[14:0];

   assign t64 = {15'b0, prod_ff};

   // sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      start_in     = start_ff;
      length_in    = length_ff;
      energy_in    = energy_ff;
      weighted_in  = weighted_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      wl_in        = wl_ff;
      val_in       = val_ff;
      prod_in      = prod_ff;
      flux_in      = flux_ff;
      rgb_in       = rgb_ff;
      eff_in       = eff_ff;
      rp_in        = rp_ff;
      gp_in        = gp_ff;
      bp_in        = bp_ff;
      dark_in      = dark_ff;
      nocolor_in   = nocolor_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      // configuration writes
      if (csr_write_en) begin
         case (csr_index)
            pfa_pkg::CSR_TABLE_START:  start_in  = csr_wdata;
            pfa_pkg::CSR_TABLE_LENGTH: length_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wl_in  = req_item.wavelength_tenths;
               val_in = req_item.sample_value;
               case (req_item.cmd)
                  pfa_pkg::CMD_SAMPLE: if (in_table) state_in = ST_MUL;
                  pfa_pkg::CMD_FINISH: state_in = ST_FLUX;
                  default: ;
               endcase
            end
         end
         // weight read is back, form energy times weight
         ST_MUL: begin
            prod_in  = 49'(val_ff) * 49'(ram_rdata);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            energy_in   = pfa_pkg::sat_add64(energy_ff, {32'b0, val_ff});
            weighted_in = pfa_pkg::sat_add64(weighted_ff, t64);
            if (wl_ff inside {[pfa_pkg::BLUE_LO:pfa_pkg::GREEN_LO - 14'd1]}) begin
               blue_in = pfa_pkg::sat_add64(blue_ff, t64);
            end else if (wl_ff inside {[pfa_pkg::GREEN_LO:pfa_pkg::RED_LO - 14'd1]}) begin
               green_in = pfa_pkg::sat_add64(green_ff, t64);
            end else if (wl_ff inside {[pfa_pkg::RED_LO:pfa_pkg::RED_HI - 14'd1]}) begin
               red_in = pfa_pkg::sat_add64(red_ff, t64);
            end
            state_in = ST_IDLE;
         end
         // flux and band total, or the dark result
         ST_FLUX: begin
            eff_in     = '0;
            rp_in      = '0;
            gp_in      = '0;
            bp_in      = '0;
            nocolor_in = 1'b0;
            if (energy_ff == 64'd0) begin
               flux_in  = '0;
               dark_in  = 1'b1;
               state_in = ST_EMIT;
            end else begin
               flux_in  = (weighted_ff > pfa_pkg::FLUX_LIMIT) ? 64'hFFFF_FFFF_FFFF_FFFF :
                          weighted_ff * pfa_pkg::FLUX_GAIN;
               rgb_in   = pfa_pkg::sat_add64(pfa_pkg::sat_add64(red_ff, green_ff), blue_ff);
               dark_in  = 1'b0;
               sel_in   = pfa_pkg::DIV_EFF;
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               case (sel_ff)
                  pfa_pkg::DIV_EFF: begin
                     eff_in = (div_quotient >
                               {{(pfa_pkg::DIV_N_W-26){1'b0}}, pfa_pkg::EFF_MAX}) ?
                              pfa_pkg::EFF_MAX : div_quotient[25:0];
                     if (rgb_ff == 64'd0) begin
                        nocolor_in = 1'b1;
                        state_in   = ST_EMIT;
                     end else begin
                        sel_in   = pfa_pkg::DIV_RED;
                        state_in = ST_DIV_GO;
                     end
                  end
                  pfa_pkg::DIV_RED: begin
                     rp_in    = pct_q;
                     sel_in   = pfa_pkg::DIV_GREEN;
                     state_in = ST_DIV_GO;
                  end
                  pfa_pkg::DIV_GREEN: begin
                     gp_in    = pct_q;
                     sel_in   = pfa_pkg::DIV_BLUE;
                     state_in = ST_DIV_GO;
                  end
                  default: begin
                     bp_in    = pct_q;
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         // hand the result to the output register and clear the sums
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_item_in.luminous_flux = flux_ff;
               rsp_item_in.efficacy      = eff_ff;
               rsp_item_in.red_percent   = rp_ff;
               rsp_item_in.green_percent = gp_ff;
               rsp_item_in.blue_percent  = bp_ff;
               rsp_item_in.dark_flag     = dark_ff;
               rsp_item_in.no_color_flag = nocolor_ff;
               rsp_valid_in = 1'b1;
               energy_in    = '0;
               weighted_in  = '0;
               red_in       = '0;
               green_in     = '0;
               blue_in      = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= pfa_pkg::DIV_EFF;
         start_ff     <= pfa_pkg::TABLE_START_RST;
         length_ff    <= pfa_pkg::TABLE_LENGTH_RST;
         energy_ff    <= '0;
         weighted_ff  <= '0;
         red_ff       <= '0;
         green_ff     <= '0;
         blue_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         start_ff     <= start_in;
         length_ff    <= length_in;
         energy_ff    <= energy_in;
         weighted_ff  <= weighted_in;
         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      wl_ff       <= wl_in;
      val_ff      <= val_in;
      prod_ff     <= prod_in;
      flux_ff     <= flux_in;
      rgb_ff      <= rgb_in;
      eff_ff      <= eff_in;
      rp_ff       <= rp_in;
      gp_ff       <= gp_in;
      bp_ff       <= bp_in;
      dark_ff     <= dark_in;
      nocolor_ff  <= nocolor_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
